// ===== sv/tlmq_pkg.sv =====
package tlmq_pkg;

    localparam int NUM_QUEUES      = 16;
    localparam int QUEUE_DEPTH     = 2048;
    localparam int DRAIN_BURST_DEF = 64;
    localparam int Q_W             = 4;
    localparam int IDX_W           = $clog2(QUEUE_DEPTH);
    localparam int LEN_W           = 12;
    localparam int THR_W           = 17;
    localparam int RC_W            = Q_W + 1;
    localparam int MEM_DEPTH       = NUM_QUEUES * QUEUE_DEPTH;
    localparam int MSG_W           = 192;
    localparam int ADDR_W          = 3;
    localparam logic [THR_W-1:0] BASE_RESET = THR_W'(1024);

    // operation codes
    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_PUSH    = 3'd1;
    localparam logic [2:0] OP_POPRDY  = 3'd2;
    localparam logic [2:0] OP_POPMSG  = 3'd3;
    localparam logic [2:0] OP_MARK    = 3'd4;
    localparam logic [2:0] OP_RELEASE = 3'd5;
    localparam logic [2:0] OP_BAD     = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // register indexes
    localparam logic REG_OVERLOAD_BASE = 1'b0;

    typedef struct packed {
        logic [2:0]        op;
        logic [Q_W-1:0]    q;
        logic [23:0]       handle;
        logic [31:0]       source;
        logic signed [31:0] session;
        logic [63:0]       data_ref;
        logic [63:0]       size_word;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [Q_W-1:0]     queue;
        logic [23:0]        owner;
        logic [31:0]        source;
        logic signed [31:0] session;
        logic [63:0]        data;
        logic [63:0]        size;
        logic [LEN_W-1:0]   length;
        logic [LEN_W-1:0]   ovl;
        logic               freed;
        logic               last;
    } res_t;

    // Threshold after a pop that leaves len > thr: smallest thr*2^k >= len,
    // where a zero threshold first becomes one.
    function automatic logic [THR_W-1:0] next_thr(input logic [THR_W-1:0] thr,
                                                  input logic [LEN_W-1:0] len);
        logic [THR_W+LEN_W-1:0] t0;
        logic [THR_W+LEN_W-1:0] cand;
        logic [THR_W-1:0]       res;
        t0  = {{LEN_W{1'b0}}, ((thr == '0) ? THR_W'(1) : thr)};
        res = thr;
        for (int k = LEN_W - 1; k >= 0; k--)
        begin
            cand = t0 << k;
            if (cand >= {{THR_W{1'b0}}, len})
            begin
                res = cand[THR_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/tlmq_ram.sv =====
module tlmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/tlmq_front.sv =====
module tlmq_front
    import tlmq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [3:0]  queue_id,
    input  logic [23:0] handle,
    input  logic [31:0] source,
    input  logic signed [31:0] session,
    input  logic [63:0] data_ref,
    input  logic [63:0] size_word,
    output cmd_t        cmd,
    output logic        cmd_valid,
    input  logic        cmd_pop
);

    // two-entry item queue toward the engine
    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       dec;
    logic       push;

    always_comb
    begin
        dec.op        = (kind > OP_RELEASE) ? OP_BAD : kind;
        dec.q         = queue_id;
        dec.handle    = handle;
        dec.source    = source;
        dec.session   = session;
        dec.data_ref  = data_ref;
        dec.size_word = size_word;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end

endmodule

// ===== sv/tlmq_engine.sv =====
module tlmq_engine
    import tlmq_pkg::*;
#(
    parameter int DRAIN_BURST = DRAIN_BURST_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    input  logic [THR_W-1:0] base,
    output res_t             res,
    output logic             res_valid,
    input  logic             res_ready
);

    localparam int BW = (DRAIN_BURST > 1) ? $clog2(DRAIN_BURST) : 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_POPEMIT = 3'd2;
    localparam logic [2:0] S_DRD     = 3'd3;
    localparam logic [2:0] S_DEMIT   = 3'd4;

    logic [2:0] state_reg, state_next;
    cmd_t       cmd_reg;
    logic [Q_W-1:0] cur_q_reg, cur_q_next;
    logic [BW-1:0]  burst_reg, burst_next;
    logic [LEN_W-1:0] lat_len_reg, lat_len_next;
    logic [LEN_W-1:0] lat_ovl_reg, lat_ovl_next;
    logic             lat_end_reg, lat_end_next;
    logic             lat_fin_reg, lat_fin_next;

    // per-queue state
    logic [IDX_W-1:0] head_reg [NUM_QUEUES];
    logic [IDX_W-1:0] tail_reg [NUM_QUEUES];
    logic [LEN_W-1:0] fill_reg [NUM_QUEUES];
    logic             rdy_reg  [NUM_QUEUES];
    logic             mark_reg [NUM_QUEUES];
    logic [LEN_W-1:0] ovl_reg  [NUM_QUEUES];
    logic [THR_W-1:0] thr_reg  [NUM_QUEUES];
    logic [23:0]      own_reg  [NUM_QUEUES];

    logic [IDX_W-1:0] head_n, tail_n;
    logic [LEN_W-1:0] fill_n, ovl_n;
    logic             rdy_n, mark_n;
    logic [THR_W-1:0] thr_n;
    logic [23:0]      own_n;
    logic             q_wr;

    logic [Q_W-1:0] ring_reg [NUM_QUEUES];
    logic [Q_W-1:0] rhead_reg, rhead_next;
    logic [RC_W-1:0] rcount_reg, rcount_next;
    logic            ring_wr;
    logic            ring_ok;
    logic [Q_W-1:0]  ring_widx;

    logic           mem_we, mem_re;
    logic [MSG_W-1:0] mem_rdata;

    res_t res_reg, res_d;
    logic res_valid_reg, res_load, out_free;

    // take_message results for cur_q
    logic [LEN_W-1:0] tk_fill;
    logic             tk_ovf;
    logic [THR_W-1:0] tk_thr;
    logic [1:0]       st;

    assign out_free  = !res_valid_reg || res_ready;
    assign ring_ok   = (rcount_reg < RC_W'(NUM_QUEUES));
    assign ring_widx = rhead_reg + rcount_reg[Q_W-1:0];
    assign tk_fill   = fill_reg[cur_q_reg] - LEN_W'(1);
    assign tk_ovf    = ({{(THR_W-LEN_W){1'b0}}, tk_fill} > thr_reg[cur_q_reg]);
    assign tk_thr    = tk_ovf ? next_thr(thr_reg[cur_q_reg], tk_fill) : thr_reg[cur_q_reg];

    always_comb
    begin
        state_next   = state_reg;
        cmd_pop      = 1'b0;
        cur_q_next   = cur_q_reg;
        burst_next   = burst_reg;
        lat_len_next = lat_len_reg;
        lat_ovl_next = lat_ovl_reg;
        lat_end_next = lat_end_reg;
        lat_fin_next = lat_fin_reg;
        head_n = head_reg[cur_q_reg];
        tail_n = tail_reg[cur_q_reg];
        fill_n = fill_reg[cur_q_reg];
        rdy_n  = rdy_reg[cur_q_reg];
        mark_n = mark_reg[cur_q_reg];
        ovl_n  = ovl_reg[cur_q_reg];
        thr_n  = thr_reg[cur_q_reg];
        own_n  = own_reg[cur_q_reg];
        q_wr   = 1'b0;
        ring_wr     = 1'b0;
        rhead_next  = rhead_reg;
        rcount_next = rcount_reg;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        res_load = 1'b0;
        st       = ST_OK;
        res_d        = '0;
        res_d.queue  = cur_q_reg;
        res_d.owner  = own_reg[cur_q_reg];
        res_d.length = fill_reg[cur_q_reg];
        res_d.last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cur_q_next = (cmd.op == OP_POPRDY) ? ring_reg[rhead_reg] : cmd.q;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.op)
                    OP_CREATE:
                    begin
                        if (out_free)
                        begin
                            q_wr = 1'b1;
                            head_n = '0; tail_n = '0; fill_n = '0;
                            mark_n = 1'b0; ovl_n = '0; thr_n = base;
                            own_n = cmd_reg.handle; rdy_n = 1'b1;
                            res_d.owner  = cmd_reg.handle;
                            res_d.length = '0;
                            res_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    OP_PUSH:
                    begin
                        if (out_free)
                        begin
                            q_wr = 1'b1;
                            if (fill_reg[cur_q_reg] >= LEN_W'(QUEUE_DEPTH))
                            begin
                                st = ST_FULL;
                                res_d.source  = cmd_reg.source;
                                res_d.session = cmd_reg.session;
                                res_d.data    = cmd_reg.data_ref;
                                res_d.size    = cmd_reg.size_word;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                tail_n = tail_reg[cur_q_reg] + IDX_W'(1);
                                fill_n = fill_reg[cur_q_reg] + LEN_W'(1);
                            end
                            if (!rdy_reg[cur_q_reg])
                            begin
                                if (ring_ok)
                                begin
                                    ring_wr     = 1'b1;
                                    rcount_next = rcount_reg + RC_W'(1);
                                    rdy_n       = 1'b1;
                                end
                                else if (st == ST_OK)
                                begin
                                    st = ST_BAD;
                                end
                            end
                            res_d.status = st;
                            res_d.length = fill_n;
                            res_load     = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    OP_POPRDY:
                    begin
                        if (out_free)
                        begin
                            if (rcount_reg == '0)
                            begin
                                res_d        = '0;
                                res_d.status = ST_EMPTY;
                                res_d.last   = 1'b1;
                            end
                            else
                            begin
                                rhead_next  = rhead_reg + Q_W'(1);
                                rcount_next = rcount_reg - RC_W'(1);
                            end
                            res_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    OP_POPMSG:
                    begin
                        if (fill_reg[cur_q_reg] == '0)
                        begin
                            if (out_free)
                            begin
                                q_wr  = 1'b1;
                                thr_n = base;
                                rdy_n = 1'b0;
                                res_d.status = ST_EMPTY;
                                res_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            q_wr   = 1'b1;
                            mem_re = 1'b1;
                            head_n = head_reg[cur_q_reg] + IDX_W'(1);
                            fill_n = tk_fill;
                            thr_n  = tk_thr;
                            ovl_n  = '0;
                            lat_len_next = tk_fill;
                            lat_ovl_next = tk_ovf ? tk_fill : ovl_reg[cur_q_reg];
                            state_next   = S_POPEMIT;
                        end
                    end
                    OP_MARK:
                    begin
                        if (out_free)
                        begin
                            if (mark_reg[cur_q_reg])
                            begin
                                st = ST_BAD;
                            end
                            else
                            begin
                                q_wr   = 1'b1;
                                mark_n = 1'b1;
                                if (!rdy_reg[cur_q_reg])
                                begin
                                    if (ring_ok)
                                    begin
                                        ring_wr     = 1'b1;
                                        rcount_next = rcount_reg + RC_W'(1);
                                    end
                                    else
                                    begin
                                        st = ST_BAD;
                                    end
                                end
                            end
                            res_d.status = st;
                            res_load     = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (!mark_reg[cur_q_reg])
                        begin
                            if (out_free)
                            begin
                                if (ring_ok)
                                begin
                                    ring_wr     = 1'b1;
                                    rcount_next = rcount_reg + RC_W'(1);
                                end
                                else
                                begin
                                    st = ST_BAD;
                                end
                                res_d.status = st;
                                res_load     = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end
                        else if (fill_reg[cur_q_reg] == '0)
                        begin
                            if (out_free)
                            begin
                                q_wr = 1'b1;
                                head_n = '0; tail_n = '0; fill_n = '0; rdy_n = 1'b0;
                                mark_n = 1'b0; ovl_n = '0; thr_n = base; own_n = '0;
                                res_d.freed = 1'b1;
                                res_load    = 1'b1;
                                state_next  = S_IDLE;
                            end
                        end
                        else
                        begin
                            burst_next = '0;
                            state_next = S_DRD;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            res_d.status = ST_BAD;
                            res_load     = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            S_POPEMIT:
            begin
                if (out_free)
                begin
                    {res_d.source, res_d.session, res_d.data, res_d.size} = mem_rdata;
                    res_d.length = lat_len_reg;
                    res_d.ovl    = lat_ovl_reg;
                    res_load     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DRD:
            begin
                q_wr   = 1'b1;
                mem_re = 1'b1;
                head_n = head_reg[cur_q_reg] + IDX_W'(1);
                fill_n = tk_fill;
                thr_n  = tk_thr;
                if (tk_ovf)
                begin
                    ovl_n = tk_fill;
                end
                lat_len_next = tk_fill;
                lat_fin_next = (tk_fill == '0);
                lat_end_next = (tk_fill == '0) || (burst_reg == BW'(DRAIN_BURST - 1));
                state_next   = S_DEMIT;
            end
            S_DEMIT:
            begin
                if (out_free)
                begin
                    {res_d.source, res_d.session, res_d.data, res_d.size} = mem_rdata;
                    res_d.length = lat_len_reg;
                    res_d.freed  = lat_fin_reg;
                    res_d.last   = lat_end_reg;
                    res_load     = 1'b1;
                    if (lat_fin_reg)
                    begin
                        q_wr = 1'b1;
                        head_n = '0; tail_n = '0; fill_n = '0; rdy_n = 1'b0;
                        mark_n = 1'b0; ovl_n = '0; thr_n = base; own_n = '0;
                    end
                    if (lat_end_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        burst_next = burst_reg + BW'(1);
                        state_next = S_DRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    tlmq_ram #(
        .WIDTH (MSG_W),
        .DEPTH (MEM_DEPTH)
    ) u_msg_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr ({cur_q_reg, tail_reg[cur_q_reg]}),
        .wdata ({cmd_reg.source, cmd_reg.session, cmd_reg.data_ref, cmd_reg.size_word}),
        .re    (mem_re),
        .raddr ({cur_q_reg, head_reg[cur_q_reg]}),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (ring_wr)
        begin
            ring_reg[ring_widx] <= cur_q_reg;
        end
        if (res_load)
        begin
            res_reg <= res_d;
        end
        cur_q_reg   <= cur_q_next;
        burst_reg   <= burst_next;
        lat_len_reg <= lat_len_next;
        lat_ovl_reg <= lat_ovl_next;
        lat_end_reg <= lat_end_next;
        lat_fin_reg <= lat_fin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rhead_reg     <= '0;
            rcount_reg    <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
                rdy_reg[i]  <= 1'b0;
                mark_reg[i] <= 1'b0;
                ovl_reg[i]  <= '0;
                thr_reg[i]  <= BASE_RESET;
                own_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            rhead_reg  <= rhead_next;
            rcount_reg <= rcount_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (q_wr)
            begin
                head_reg[cur_q_reg] <= head_n;
                tail_reg[cur_q_reg] <= tail_n;
                fill_reg[cur_q_reg] <= fill_n;
                rdy_reg[cur_q_reg]  <= rdy_n;
                mark_reg[cur_q_reg] <= mark_n;
                ovl_reg[cur_q_reg]  <= ovl_n;
                thr_reg[cur_q_reg]  <= thr_n;
                own_reg[cur_q_reg]  <= own_n;
            end
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

// ===== sv/two_level_message_queue.sv =====
// Two-level message queue: sixteen per-service ring queues of messages in
// one shared message RAM, plus a ready ring of queue ids.
//
// Input channel (in_valid/in_ready): one operation per item, selected by
// kind. Items land in a two-entry queue, so the sender keeps going while
// the engine is busy or the output is stalled.
// Output channel (out_valid/out_ready): one result per item, except a
// release of a marked queue, which drains up to DRAIN_BURST messages as a
// run of results; the final result of every run has last set.
// An accepted item waits in the item queue, goes to the engine's command
// register from idle, and its result is registered in the execute state (pop
// message: in a later emit state, after the RAM's registered read). The engine
// takes no new item until idle again; a drain reads, then emits, each message.
// Configuration: APB register 0 (overload_base) at address 0, write only
// while the block is idle. Reset clears all queue state; the message RAM
// is not cleared and needs no clearing pass.
// Receiver stall: the output register holds its result; the engine waits
// and, once the item queue is full, in_ready drops.
module two_level_message_queue
    import tlmq_pkg::*;
#(
    parameter int DRAIN_BURST = DRAIN_BURST_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        kind,
    input  logic [3:0]        queue_id,
    input  logic [23:0]       handle,
    input  logic [31:0]       source,
    input  logic signed [31:0] session,
    input  logic [63:0]       data_ref,
    input  logic [63:0]       size_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [3:0]        result_queue,
    output logic [23:0]       owner_handle,
    output logic [31:0]       msg_source,
    output logic signed [31:0] msg_session,
    output logic [63:0]       msg_data,
    output logic [63:0]       msg_size,
    output logic [11:0]       length,
    output logic [11:0]       overload_seen,
    output logic              freed,
    output logic              last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [THR_W-1:0] base_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    logic             cmd_valid, cmd_pop;
    res_t             res;

    // config port; the register index is the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OVERLOAD_BASE);
    assign prdata = (paddr[2] == REG_OVERLOAD_BASE) ? {{(32-THR_W){1'b0}}, base_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_wr)
        begin
            base_reg <= pwdata[THR_W-1:0];
        end
    end

    tlmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .queue_id  (queue_id),
        .handle    (handle),
        .source    (source),
        .session   (session),
        .data_ref  (data_ref),
        .size_word (size_word),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    tlmq_engine #(
        .DRAIN_BURST (DRAIN_BURST)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .base      (base_reg),
        .res       (res),
        .res_valid (out_valid),
        .res_ready (out_ready)
    );

    assign status        = res.status;
    assign result_queue  = res.queue;
    assign owner_handle  = res.owner;
    assign msg_source    = res.source;
    assign msg_session   = res.session;
    assign msg_data      = res.data;
    assign msg_size      = res.size;
    assign length        = res.length;
    assign overload_seen = res.ovl;
    assign freed         = res.freed;
    assign last          = res.last;

    // a freed queue always ends its run with nothing left
    a_freed_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && freed |-> last && (length == '0))
        else $error("freed result not final or not empty");

    // empty results carry no message and no overload report
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |->
            (msg_source == '0) && (length == '0) && (overload_seen == '0))
        else $error("empty result carries data");

    // a register write lands in the overload base
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> base_reg == $past(pwdata[THR_W-1:0]))
        else $error("overload base write lost");

    // overload is only reported by an ok pop
    a_ovl_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (overload_seen != '0) |-> (status == ST_OK) && !freed)
        else $error("overload report on wrong result");

endmodule
